// ----- hdl/tvp_pkg.sv -----
// Types and constants shared by the trapezoid velocity profile block.
package tvp_pkg;

  localparam int unsigned VEL_W    = 24;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Serial multiplier: multiplier word shifted out one digit per cycle
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_B_W   = 24;
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_STEPS = MUL_B_W / DIGIT_W;
  localparam int unsigned FRAC_W    = 16;

  localparam logic [1:0] PH_RUN   = 2'd0;
  localparam logic [1:0] PH_BRAKE = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TWICE_ACC = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] distance;
  } in_beat_t;

  typedef struct packed {
    logic [VEL_W-1:0] velocity;
    logic [POS_W-1:0] position;
    logic [1:0]       phase;
    logic             last;
  } out_beat_t;

endpackage

// ----- hdl/trapezoid_velocity_profile.sv -----
// Trapezoidal velocity profile generator: one sample per tick beat of a running move.
//
// Input channel (in_valid / in_stall / in_data): a start beat loads the
// magnitude of the move distance and clears velocity, position and braking
// distance; it yields no result. A tick beat advances one sample and yields
// one result beat on the output channel (out_valid / out_stall / out_data),
// unless the move has finished or never started. One item is in work at a
// time. A decelerating tick runs one serial multiply for the position step
// (one 4-bit digit per cycle), then a decision step that picks the next phase
// and fills the output register; the next beat is taken once the block is idle.
// An accelerating or cruising tick adds two more serial multiplies for the
// braking distance (v squared, then times the inverse of twice the acceleration)
// before the decision step. All three multiplies share one digit-serial
// multiplier. The result sits in an output register; a new beat is accepted
// while it waits. If the receiver still stalls when the next result is ready,
// hold it in the decision step, with the input stalled, until the register
// frees. Configuration (cfg_write_enable / cfg_index / cfg_data) is to be
// written only while the block is idle; the block itself does not enforce it.
// Synchronous reset sets the configuration and profile registers to their
// defaults and leaves the profile finished, so ticks produce nothing until a start.
module trapezoid_velocity_profile (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tvp_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tvp_pkg::out_beat_t                  out_data,
  input  logic                                cfg_write_enable,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tvp_pkg::CFG_W-1:0]           cfg_data
);

  import tvp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MUL_STEPS);
  localparam int unsigned PP_W   = MUL_A_W + DIGIT_W;
  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
  localparam int unsigned SHR_W  = PROD_W - FRAC_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS_MUL,
    S_SQ_MUL,
    S_BRK_MUL,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration
  logic [VEL_W-1:0]    max_velocity;
  logic [VEL_W-1:0]    velocity_step;
  logic [PERIOD_W-1:0] sample_period;
  logic [VEL_W-1:0]    inverse_twice_accel;

  // Profile state
  logic [VEL_W-1:0] velocity;
  logic [POS_W-1:0] travelled;
  logic [POS_W-1:0] braking;
  logic [POS_W-1:0] target;
  logic [1:0]       phase;
  logic [1:0]       sample_phase;

  // Serial multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_A_W-1:0] acc;
  logic [CNT_W-1:0]   mcount;

  logic [PP_W-1:0]   pp;
  logic [PP_W-1:0]   sum;
  logic [PROD_W-1:0] prod_next;
  logic [SHR_W-1:0]  prod_shr;

  logic               in_take;
  logic [VEL_W:0]     vel_inc;
  logic [VEL_W-1:0]   vel_next;
  logic [POS_W-1:0]   dist_mag;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   travelled_next;
  logic [POS_W-1:0]   braking_next;
  logic [POS_W:0]     reach;
  logic               keep_run;
  logic               keep_brake;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !(out_valid && out_stall);

  always_comb begin
    pp        = PP_W'(mul_a) * PP_W'(mul_b[DIGIT_W-1:0]);
    sum       = PP_W'(acc) + pp;
    // Low digits of the product fill the multiplier word as it empties
    prod_next = {sum, mul_b[MUL_B_W-1:DIGIT_W]};
    prod_shr  = prod_next[PROD_W-1:FRAC_W];
  end

  always_comb begin
    vel_inc = {1'b0, velocity} + {1'b0, velocity_step};
    if (phase == PH_RUN) begin
      if (velocity < max_velocity) begin
        vel_next = vel_inc[VEL_W] ? {VEL_W{1'b1}} : vel_inc[VEL_W-1:0];
      end else begin
        vel_next = max_velocity;
      end
    end else begin
      vel_next = (velocity > velocity_step) ? velocity - velocity_step : '0;
    end
  end

  always_comb begin
    dist_mag       = in_data.distance[31] ? POS_W'(0) - POS_W'(in_data.distance)
                                          : POS_W'(in_data.distance);
    pos_sum        = {1'b0, travelled} + (POS_W + 1)'(prod_shr[VEL_W-1:0]);
    travelled_next = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    braking_next   = (prod_shr[SHR_W-1:POS_W] != '0) ? {POS_W{1'b1}}
                                                     : prod_shr[POS_W-1:0];
    reach          = {1'b0, travelled} + {1'b0, braking};
    keep_run       = (sample_phase == PH_RUN) && (reach <= {1'b0, target});
    keep_brake     = (travelled <= target) && (velocity != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      out_valid           <= 1'b0;
      max_velocity        <= '0;
      velocity_step       <= '0;
      sample_period       <= PERIOD_W'(1);
      inverse_twice_accel <= '0;
      velocity            <= '0;
      travelled           <= '0;
      braking             <= '0;
      target              <= '0;
      phase               <= PH_DONE;
      sample_phase        <= PH_DONE;
      mcount              <= '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_MAX_VELOCITY:  max_velocity        <= cfg_data;
          REG_VELOCITY_STEP: velocity_step       <= cfg_data;
          REG_SAMPLE_PERIOD: sample_period       <= cfg_data[PERIOD_W-1:0];
          REG_INV_TWICE_ACC: inverse_twice_accel <= cfg_data;
          default: ;
        endcase
      end

      // The decision step refills the register itself
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_data.operation == OP_START) begin
              target    <= dist_mag;
              velocity  <= '0;
              travelled <= '0;
              braking   <= '0;
              phase     <= PH_RUN;
            end else if (phase == PH_RUN || phase == PH_BRAKE) begin
              velocity     <= vel_next;
              sample_phase <= phase;
              mul_a        <= MUL_A_W'(vel_next);
              mul_b        <= MUL_B_W'(sample_period);
              acc          <= '0;
              mcount       <= '0;
              state        <= S_POS_MUL;
            end
          end
        end

        S_POS_MUL, S_SQ_MUL, S_BRK_MUL: begin
          if (mcount != CNT_LAST) begin
            acc    <= sum[PP_W-1:DIGIT_W];
            mul_b  <= {sum[DIGIT_W-1:0], mul_b[MUL_B_W-1:DIGIT_W]};
            mcount <= mcount + CNT_W'(1);
          end else begin
            acc    <= '0;
            mcount <= '0;
            case (state)
              S_POS_MUL: begin
                travelled <= travelled_next;
                if (sample_phase == PH_RUN) begin
                  mul_a <= MUL_A_W'(velocity);
                  mul_b <= MUL_B_W'(velocity);
                  state <= S_SQ_MUL;
                end else begin
                  state <= S_FINISH;
                end
              end
              S_SQ_MUL: begin
                mul_a <= prod_shr[MUL_A_W-1:0];
                mul_b <= MUL_B_W'(inverse_twice_accel);
                state <= S_BRK_MUL;
              end
              default: begin
                braking <= braking_next;
                state   <= S_FINISH;
              end
            endcase
          end
        end

        S_FINISH: begin
          // Hold the decision until the output register frees
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data.velocity <= velocity;
            out_data.position <= travelled;
            out_data.phase    <= sample_phase;
            if (keep_run) begin
              phase         <= PH_RUN;
              out_data.last <= 1'b0;
            end else if (keep_brake) begin
              phase         <= PH_BRAKE;
              out_data.last <= 1'b0;
            end else begin
              phase         <= PH_DONE;
              out_data.last <= 1'b1;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/trapezoid_velocity_profile_tb.sv -----
// Testbench for the trapezoid velocity profile block: predicted samples versus output beats.
`timescale 1ns / 100ps

module trapezoid_velocity_profile_tb;
  import tvp_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 450;
  localparam int PHASES        = 8;

  class profile_scoreboard;
    logic [VEL_W-1:0]    cap_vel;
    logic [VEL_W-1:0]    accel_step;
    logic [PERIOD_W-1:0] tick_period;
    logic [CFG_W-1:0]    brake_gain;
    logic [VEL_W-1:0]    cmd_vel;
    logic [POS_W-1:0]    run_pos;
    logic [POS_W-1:0]    stop_dist;
    logic [POS_W-1:0]    goal;
    logic [1:0]          stage;
    out_beat_t           expected_samples[$];
    int                  mismatches;

    function new();
      cap_vel     = '0;
      accel_step  = '0;
      tick_period = 16'd1;
      brake_gain  = '0;
      cmd_vel     = '0;
      run_pos     = '0;
      stop_dist   = '0;
      goal        = '0;
      stage       = PH_DONE;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_MAX_VELOCITY:  cap_vel = value;
        REG_VELOCITY_STEP: accel_step = value;
        REG_SAMPLE_PERIOD: tick_period = value[PERIOD_W-1:0];
        REG_INV_TWICE_ACC: brake_gain = value;
        default: ;
      endcase
    endfunction

    // Advance the profile by one accepted beat; returns 1 if the beat counts
    // as work (a start, or a tick that yields a sample).
    function bit predict_sample(in_beat_t beat);
      logic [63:0] prod;
      logic [63:0] sum;
      logic [24:0] raised;
      logic [1:0]  prior;
      out_beat_t   sample;
      if (beat.operation == OP_START) begin
        goal      = beat.distance[31] ? (32'd0 - $unsigned(beat.distance))
                                      : $unsigned(beat.distance);
        cmd_vel   = '0;
        run_pos   = '0;
        stop_dist = '0;
        stage     = PH_RUN;
        return 1'b1;
      end
      if (stage != PH_RUN && stage != PH_BRAKE) return 1'b0;
      prior = stage;
      if (stage == PH_RUN) begin
        if (cmd_vel < cap_vel) begin
          raised  = {1'b0, cmd_vel} + {1'b0, accel_step};
          cmd_vel = raised[24] ? 24'hFF_FFFF : raised[23:0];
        end else begin
          cmd_vel = cap_vel;
        end
      end else begin
        cmd_vel = (cmd_vel > accel_step) ? cmd_vel - accel_step : '0;
      end
      prod = ({40'd0, cmd_vel} * {48'd0, tick_period}) >> 16;
      sum  = {32'd0, run_pos} + prod;
      run_pos = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      if (prior == PH_RUN) begin
        prod = ({40'd0, cmd_vel} * {40'd0, cmd_vel}) >> 16;
        prod = (prod * {40'd0, brake_gain}) >> 16;
        stop_dist = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      end
      sample.last = 1'b0;
      if (prior == PH_RUN && ({32'd0, run_pos} + {32'd0, stop_dist}) <= {32'd0, goal}) begin
        stage = PH_RUN;
      end else if (run_pos <= goal && cmd_vel != '0) begin
        stage = PH_BRAKE;
      end else begin
        stage = PH_DONE;
        sample.last = 1'b1;
      end
      sample.velocity = cmd_vel;
      sample.position = run_pos;
      sample.phase    = prior;
      expected_samples = {expected_samples, sample};
      return 1'b1;
    endfunction

    function void check_sample(out_beat_t got);
      out_beat_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample: vel %h pos %h phase %0d last %0d",
                   got.velocity, got.position, got.phase, got.last);
        return;
      end
      want = expected_samples.pop_front();
      if (got.velocity !== want.velocity || got.position !== want.position ||
          got.phase !== want.phase || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("sample mismatch: expected vel %h pos %h phase %0d last %0d, ",
                 want.velocity, want.position, want.phase, want.last);
          $display("got vel %h pos %h phase %0d last %0d",
                   got.velocity, got.position, got.phase, got.last);
        end
      end
    endfunction

    function int outstanding();
      return expected_samples.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  profile_scoreboard sb = new();
  int cycles = 0;
  int work_items = 0;
  int burst_left = 0;
  int hold_requests = 0;

  trapezoid_velocity_profile i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: check accepted beats, then pick the next stall pattern.
  int stall_left = 0;
  int free_left = 0;
  int holds_served = 0;
  int pick;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_sample(out_data);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else if (holds_served != hold_requests) begin
      // long hold so that the block backs up into its input
      holds_served = hold_requests;
      stall_left = 400;
      out_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        stall_left = $urandom_range(20, 80);
        out_stall <= 1'b1;
      end else if (pick < 45) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else if (pick < 90) begin
        free_left = $urandom_range(0, 15);
        out_stall <= 1'b0;
      end else begin
        free_left = $urandom_range(30, 100);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(logic op, logic [31:0] move_len);
    int gap;
    int r;
    in_beat_t beat;
    beat.operation = op;
    beat.distance  = move_len;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    if (sb.predict_sample(beat)) work_items++;
  endtask

  task automatic run_ticks(int max_ticks);
    int n;
    n = 0;
    while (sb.stage != PH_DONE && n < max_ticks) begin
      send_beat(OP_TICK, $urandom());
      n++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic load_profile(logic [23:0] cap, logic [23:0] step, logic [15:0] period,
                              logic [23:0] gain);
    write_reg(REG_MAX_VELOCITY, cap);
    write_reg(REG_VELOCITY_STEP, step);
    write_reg(REG_SAMPLE_PERIOD, {8'd0, period});
    write_reg(REG_INV_TWICE_ACC, gain);
    cfg_write_enable <= 1'b0;
  endtask

  // Drop valid, drain every expected sample, then let a silent tick finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random profile whose braking gain matches the step and period, at times with a random offset added.
  task automatic random_profile(bit zero_period);
    logic [23:0] cap;
    logic [23:0] step;
    logic [15:0] period;
    logic [63:0] gain;
    cap    = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(1, 24'h00_FFFF))
                                         : 24'($urandom_range(1, 24'hFF_FFFF));
    step   = 24'(cap / $urandom_range(1, 8));
    if (step == '0) step = 24'd1;
    period = zero_period ? 16'd0 : 16'($urandom_range(1, 16'hFFFF));
    gain   = ({48'd0, period} << 16) / (2 * {40'd0, step});
    if ($urandom_range(0, 3) == 0) gain = gain + 64'($urandom_range(0, 16'hFFFF));
    if (gain > 64'hFF_FFFF) gain = 64'hFF_FFFF;
    load_profile(cap, step, period, gain[23:0]);
  endtask

  task automatic random_move();
    int kind;
    logic [63:0] span;
    logic [63:0] mag;
    logic [31:0] move_len;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) send_beat(1'($urandom_range(0, 1)), $urandom());
      return;
    end
    span = ({40'd0, sb.cap_vel} * {48'd0, sb.tick_period}) >> 16;
    if (kind < 14 || span == '0) mag = 64'($urandom());
    else mag = span * 64'($urandom_range(0, 25)) + 64'($urandom_range(0, span[31:0]));
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    move_len = $urandom_range(0, 1) ? (32'd0 - mag[31:0]) : mag[31:0];
    send_beat(OP_START, move_len);
    // short runs are broken off by the next start
    run_ticks((kind < 24) ? $urandom_range(0, 4) : 60);
    repeat ($urandom_range(0, 2)) send_beat(OP_TICK, $urandom());
  endtask

  initial begin
    int ph;
    int mark;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // tick before any start yields nothing; zero step makes no progress
    send_beat(OP_TICK, 32'hFFFF_FFFF);
    send_beat(OP_START, 32'h0000_0000);
    send_beat(OP_TICK, 32'h0);
    send_beat(OP_TICK, 32'h0);
    wait_idle();

    // accelerate, cruise, brake, then a tick while finished
    load_profile(24'h01_0000, 24'h00_4000, 16'h1000, 24'h00_2000);
    send_beat(OP_START, 32'h0000_8000);
    run_ticks(20);
    send_beat(OP_TICK, 32'h0);
    send_beat(OP_START, 32'hFFFF_D000);
    run_ticks(20);
    wait_idle();

    load_profile(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
    send_beat(OP_START, 32'h8000_0000);
    run_ticks(6);
    send_beat(OP_START, 32'h7FFF_FFFF);
    run_ticks(6);
    wait_idle();

    // zero sample period: velocity rises but position holds
    load_profile(24'h01_0000, 24'h00_4000, 16'h0000, 24'h00_2000);
    send_beat(OP_START, 32'h0000_0100);
    run_ticks(6);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: load_profile(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
        3: load_profile(24'h00_0000, 24'h00_0000, 16'h0001, 24'h00_0000);
        5: random_profile(1'b1);
        default: random_profile(1'b0);
      endcase
      if (ph == 2 || ph == 6) hold_requests++;
      mark = work_items;
      while (work_items - mark < RANDOM_ITEMS / PHASES) random_move();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
